// ===== rtl/core/lmdd_pkg.sv =====
// ----------------------------------------------------------------------------
// lmdd_pkg
// Shared types and constants for the LED matrix digit display.
// ----------------------------------------------------------------------------
package lmdd_pkg;

    localparam int ROWS       = 16;
    localparam int COLS       = 64;
    localparam int WATCHED    = 4;
    localparam int DIGIT_ROWS = 10;
    localparam int SIGN_ROW   = 14;
    localparam int SLOT_W     = 2;
    localparam int ROW_W      = 4;
    localparam int COL_W      = 7;
    localparam int UNIT_W     = 5;
    localparam int COL_OFS    = 2;

    typedef enum logic [1:0] {
        ACT_SCAN  = 2'd0,
        ACT_DIGIT = 2'd1,
        ACT_SIGN  = 2'd2,
        ACT_LOAD  = 2'd3
    } t_action;

    localparam logic KIND_ROW     = 1'b0;
    localparam logic KIND_REFRESH = 1'b1;

    typedef struct packed {
        logic [1:0]  action;
        logic [4:0]  unit;
        logic [3:0]  digit;
        logic [3:0]  value;
        logic [4:0]  watch_a;
        logic [4:0]  watch_b;
        logic [4:0]  watch_c;
        logic [4:0]  watch_d;
    } t_in_req;

    typedef struct packed {
        logic        kind;
        logic [3:0]  row_address;
        logic [63:0] row_bits;
    } t_out_req;

    // controller -> datapath
    typedef struct packed {
        logic scan;
        logic digit;
        logic sign;
        logic load;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic hit;
    } t_dp_stat;

    typedef enum logic {
        ST_EMPTY = 1'b0,
        ST_FULL  = 1'b1
    } t_ctl_state;

endpackage

// ===== rtl/core/lmdd_datapath.sv =====
// ----------------------------------------------------------------------------
// lmdd_datapath
// Frame store, watched set, scan row counter and output register.
// ----------------------------------------------------------------------------
module lmdd_datapath
    import lmdd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_in_req  i_req,
    input  t_dp_cmd  i_cmd,
    output t_dp_stat o_stat,
    output t_out_req o_out
);

    logic [COLS-1:0]   r_frame [ROWS];
    logic [COLS-1:0]   n_frame [ROWS];
    logic [UNIT_W-1:0] r_watch [WATCHED];
    logic [UNIT_W-1:0] n_watch [WATCHED];
    logic [UNIT_W-1:0] load_units [4];
    logic [ROW_W-1:0]  r_scan_row;
    t_out_req          r_out;

    logic              found;
    logic [SLOT_W-1:0] slot;
    logic [COL_W-1:0]  col;
    logic [5:0]        bit_idx;

    assign load_units[0] = i_req.watch_a;
    assign load_units[1] = i_req.watch_b;
    assign load_units[2] = i_req.watch_c;
    assign load_units[3] = i_req.watch_d;

    // first matching watched unit gives the slot
    always_comb begin
        found = 1'b0;
        slot  = '0;
        for (int i = 0; i < WATCHED; i++) begin
            if (!found && r_watch[i] == i_req.unit) begin
                found = 1'b1;
                slot  = SLOT_W'(i);
            end
        end
    end

    assign col        = COL_W'({slot, 4'b0000}) + COL_W'(COL_OFS) + COL_W'(i_req.digit);
    assign o_stat.hit = found && (col < COL_W'(COLS));
    assign bit_idx    = 6'(COLS - 1) - col[5:0];

    always_comb begin
        n_frame = r_frame;
        n_watch = r_watch;
        if (i_cmd.load) begin
            for (int r = 0; r < ROWS; r++) begin
                n_frame[r] = '1;
            end
            for (int i = 0; i < WATCHED; i++) begin
                n_watch[i] = load_units[i];
            end
        end else if (i_cmd.digit) begin
            // row DIGIT_ROWS-value lit, others dark
            for (int r = 1; r <= DIGIT_ROWS; r++) begin
                n_frame[r][bit_idx] = (i_req.value != 4'(DIGIT_ROWS - r));
            end
        end else if (i_cmd.sign) begin
            n_frame[SIGN_ROW][bit_idx] = (i_req.value == 4'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < ROWS; r++) begin
                r_frame[r] <= '1;
            end
            for (int i = 0; i < WATCHED; i++) begin
                r_watch[i] <= UNIT_W'(i + 1);
            end
            r_scan_row <= '0;
        end else begin
            r_frame <= n_frame;
            r_watch <= n_watch;
            if (i_cmd.scan) begin
                r_scan_row <= r_scan_row + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan) begin
            r_out.kind        <= KIND_ROW;
            r_out.row_address <= r_scan_row;
            r_out.row_bits    <= r_frame[r_scan_row];
        end else if (i_cmd.load) begin
            r_out.kind        <= KIND_REFRESH;
            r_out.row_address <= '0;
            r_out.row_bits    <= '0;
        end
    end

    assign o_out = r_out;

endmodule

// ===== rtl/core/lmdd_ctrl.sv =====
// ----------------------------------------------------------------------------
// lmdd_ctrl
// Handshake control: accepts requests, issues datapath commands, tracks
// whether the output register holds an undelivered result.
// ----------------------------------------------------------------------------
module lmdd_ctrl
    import lmdd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_action,
    output logic       o_in_stall,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    input  t_dp_stat   i_stat,
    output t_dp_cmd    o_cmd
);

    t_ctl_state r_state;
    t_ctl_state n_state;
    logic       accept;
    logic       produce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_EMPTY;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_in_stall  = (r_state == ST_FULL) && i_out_stall;
        o_out_valid = (r_state == ST_FULL);
        accept      = i_in_valid && !o_in_stall;

        o_cmd.scan  = accept && (i_action == ACT_SCAN);
        o_cmd.load  = accept && (i_action == ACT_LOAD);
        o_cmd.digit = accept && (i_action == ACT_DIGIT) && i_stat.hit;
        o_cmd.sign  = accept && (i_action == ACT_SIGN) && i_stat.hit;
        produce     = o_cmd.scan || o_cmd.load;

        n_state = r_state;
        case (r_state)
            ST_EMPTY: begin
                if (produce) begin
                    n_state = ST_FULL;
                end
            end
            ST_FULL: begin
                if (!i_out_stall && !produce) begin
                    n_state = ST_EMPTY;
                end
            end
            default: begin
                n_state = ST_EMPTY;
            end
        endcase
    end

endmodule

// ===== rtl/core/led_matrix_digit_display.sv =====
// ----------------------------------------------------------------------------
// led_matrix_digit_display
// 16x64 active-low LED matrix framebuffer with watched-unit digit updates.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------
//  in      | input     | i_in_valid / o_in_stall   | i_in_data  (t_in_req)
//  out     | output    | o_out_valid / i_out_stall | o_out_data (t_out_req)
//
//  One request per cycle: each request is handled in the cycle it is
//  accepted, and a scan or load result lands in the output register on the
//  following edge. Only that output register limits throughput: a new request
//  is taken while it is empty or while its result is being taken.
//  Reset (synchronous, i_rst_n low) blanks the frame to all ones, loads
//  watched units 1..4, zeros the scan row and empties the output register.
//  A stall on the output holds the result; the input then stalls too.
// ----------------------------------------------------------------------------
module led_matrix_digit_display
    import lmdd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_req o_out_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // request sequencing and output register occupancy
    lmdd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_action    (i_in_data.action),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // frame store, watch table, row counter, result register
    lmdd_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_in_data),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_out   (o_out_data)
    );

endmodule
